@@ hw/rtl/ramt_pkg.sv @@
// Types, request codes and node update functions for the range add/set min-max tree.
`default_nettype none
package ramt_pkg;

  localparam int LEAVES = 1024;
  localparam int VW = 48;
  localparam int PW = 11;

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_ADD   = 2'd1;
  localparam logic [1:0] REQ_SET   = 2'd2;
  localparam logic [1:0] REQ_QUERY = 2'd3;

  localparam logic signed [VW-1:0] VMAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [VW-1:0] VMIN = 48'sh8000_0000_0000;

  typedef struct packed {
    logic                 fresh;
    logic signed [VW-1:0] mn;
    logic [PW-1:0]        pos;
    logic signed [VW-1:0] mx;
    logic                 setp;
    logic signed [VW-1:0] setv;
    logic signed [VW-1:0] add;
  } node_t;

  function automatic logic signed [VW-1:0] sat_add(input logic signed [VW-1:0] a,
                                                   input logic signed [VW-1:0] b);
    logic [VW:0] s;
    s = {a[VW-1], a} + {b[VW-1], b};
    if (s[VW] != s[VW-1]) begin
      sat_add = s[VW] ? VMIN : VMAX;
    end else begin
      sat_add = s[VW-1:0];
    end
  endfunction

  function automatic node_t fresh_sub(input node_t n, input logic [PW-1:0] l);
    node_t r;
    r = n;
    if (n.fresh) begin
      r      = '0;
      r.mn   = VMAX;
      r.pos  = l;
    end
    return r;
  endfunction

  function automatic node_t apply_set(input node_t n, input logic [PW-1:0] l,
                                      input logic signed [VW-1:0] v);
    node_t r;
    r       = n;
    r.fresh = 1'b0;
    r.setp  = 1'b1;
    r.setv  = v;
    r.add   = '0;
    r.mn    = v;
    r.mx    = v;
    r.pos   = l;
    return r;
  endfunction

  function automatic node_t apply_add(input node_t n, input logic signed [VW-1:0] v);
    node_t r;
    r       = n;
    r.fresh = 1'b0;
    r.add   = sat_add(n.add, v);
    r.mn    = sat_add(n.mn, v);
    r.mx    = sat_add(n.mx, v);
    return r;
  endfunction

  function automatic node_t push_child(input node_t c, input node_t p,
                                       input logic [PW-1:0] l);
    node_t r;
    r = c;
    if (p.setp) begin
      r = apply_set(r, l, p.setv);
    end
    if (p.add != '0) begin
      r = apply_add(r, p.add);
    end
    return r;
  endfunction

  function automatic node_t pull_up(input node_t p, input node_t a, input node_t b);
    node_t r;
    r       = p;
    r.fresh = 1'b0;
    if (a.mn <= b.mn) begin
      r.mn  = a.mn;
      r.pos = a.pos;
    end else begin
      r.mn  = b.mn;
      r.pos = b.pos;
    end
    r.mx = (a.mx > b.mx) ? a.mx : b.mx;
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/ramt_ram.sv @@
// Generic simple dual-port RAM with registered read.
`default_nettype none
module ramt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

@@ hw/rtl/range_add_set_min_max_tree.sv @@
// Top level: lazy segment tree with range add, range set and range min/max query.
//
// Requests enter on start while busy is low, with req_type_i, range_low_i,
// range_high_i and value_i. Clear, add and set give no result. A query gives
// one result: result_valid_o is high for exactly one cycle with min_value_o,
// min_position_o and max_value_o. The receiver cannot stall.
// Node state lives in one RAM of 2*LEAVES entries with registered read.
// A request walks the tree with an explicit stack; a fully covered node is
// updated or read in place, a partly covered node gets push-down and, for
// all but a query, pull-up. An empty range does not walk the tree; an empty
// query gives its empty result straight from idle. A query result is registered
// from the final return of the walk.
// Clear, a write of active_size, and reset each start a clearing pass over
// all 2*LEAVES entries that marks every entry fresh; busy is high during it.
// The config channel (cfg_valid_i/cfg_ready_o/cfg_data_i) is ready only while
// idle with no request offered; it saturates active_size to 1..LEAVES and
// starts the clearing pass.
`default_nettype none
module range_add_set_min_max_tree (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [1:0]                     req_type_i,
  input  wire logic [ramt_pkg::PW-1:0]        range_low_i,
  input  wire logic [ramt_pkg::PW-1:0]        range_high_i,
  input  wire logic signed [ramt_pkg::VW-1:0] value_i,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [ramt_pkg::PW-1:0]        cfg_data_i,
  output logic                                result_valid_o,
  output logic signed [ramt_pkg::VW-1:0]      min_value_o,
  output logic [ramt_pkg::PW-1:0]             min_position_o,
  output logic signed [ramt_pkg::VW-1:0]      max_value_o
);

  localparam int LEAVES  = ramt_pkg::LEAVES;
  localparam int PW      = ramt_pkg::PW;
  localparam int VW      = ramt_pkg::VW;
  localparam int NODES   = 2 * LEAVES;
  localparam int AW      = $clog2(NODES);
  localparam int NW      = AW + 1;
  localparam int SD      = $clog2(LEAVES) + 1;
  localparam int SIW     = $clog2(SD);
  localparam int SPW     = $clog2(SD + 1);
  localparam int ACT_RST = (LEAVES < 1024) ? LEAVES : 1024;
  localparam int EW      = $bits(ramt_pkg::node_t);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLR    = 4'd1;
  localparam logic [3:0] S_ENTER  = 4'd2;
  localparam logic [3:0] S_NODE   = 4'd3;
  localparam logic [3:0] S_PL     = 4'd4;
  localparam logic [3:0] S_PR     = 4'd5;
  localparam logic [3:0] S_PW     = 4'd6;
  localparam logic [3:0] S_DESC   = 4'd7;
  localparam logic [3:0] S_AFTERL = 4'd8;
  localparam logic [3:0] S_FIN    = 4'd9;
  localparam logic [3:0] S_U0     = 4'd10;
  localparam logic [3:0] S_UL     = 4'd11;
  localparam logic [3:0] S_UR     = 4'd12;
  localparam logic [3:0] S_RET    = 4'd13;

  logic [3:0]           state_q, state_d;
  logic [AW-1:0]        cnt_q, cnt_d;
  logic [PW-1:0]        active_q, active_d;
  logic [1:0]           req_q, req_d;
  logic [PW-1:0]        ql_q, ql_d, qr_q, qr_d;
  logic signed [VW-1:0] val_q, val_d;
  logic [NW-1:0]        nd_q, nd_d;
  logic [PW-1:0]        l_q, l_d, r_q, r_d;
  logic [SPW-1:0]       sp_q, sp_d;
  ramt_pkg::node_t      par_q, par_d, lch_q, lch_d;
  logic signed [VW-1:0] acc_mn_q, acc_mn_d, acc_mx_q, acc_mx_d;
  logic [PW-1:0]        acc_pos_q, acc_pos_d;
  logic                 res_q, res_d;

  logic [NW-1:0] stk_nd [SD];
  logic [PW-1:0] stk_l  [SD];
  logic [PW-1:0] stk_r  [SD];
  logic          stk_ph [SD];
  logic          push, push_ph;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  ramt_pkg::node_t wdata, rd_raw, rd_n;
  logic [EW-1:0]   rdata;
  logic [PW-1:0]   rd_l, mid, mid1, lo_c, hi_c;
  logic [NW-1:0]   lc, rc;
  logic            lc_ok, rc_ok, nd_ok, covered, accept;
  logic [SIW-1:0]  top;

  assign busy        = (state_q != S_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = !busy && !start;

  assign result_valid_o = res_q;
  assign min_value_o    = acc_mn_q;
  assign min_position_o = acc_pos_q;
  assign max_value_o    = acc_mx_q;

  assign mid     = l_q + ((r_q - l_q) >> 1);
  assign mid1    = mid + PW'(1);
  assign lc      = {nd_q[NW-2:0], 1'b0};
  assign rc      = {nd_q[NW-2:0], 1'b1};
  assign lc_ok   = (lc < NW'(NODES));
  assign rc_ok   = (rc < NW'(NODES));
  assign nd_ok   = (nd_q < NW'(NODES));
  assign covered = (ql_q <= l_q) && (r_q <= qr_q);
  assign top     = SIW'(sp_q - SPW'(1));

  assign lo_c = (range_low_i == '0) ? PW'(1) : range_low_i;
  assign hi_c = (range_high_i > active_q) ? active_q : range_high_i;

  assign rd_raw = ramt_pkg::node_t'(rdata);
  assign rd_l   = (state_q == S_PR || state_q == S_UR) ? mid1 : l_q;
  assign rd_n   = ramt_pkg::fresh_sub(rd_raw, rd_l);

  ramt_ram #(
    .WIDTH(EW),
    .DEPTH(NODES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    active_d  = active_q;
    req_d     = req_q;
    ql_d      = ql_q;
    qr_d      = qr_q;
    val_d     = val_q;
    nd_d      = nd_q;
    l_d       = l_q;
    r_d       = r_q;
    sp_d      = sp_q;
    par_d     = par_q;
    lch_d     = lch_q;
    acc_mn_d  = acc_mn_q;
    acc_mx_d  = acc_mx_q;
    acc_pos_d = acc_pos_q;
    res_d     = 1'b0;
    push      = 1'b0;
    push_ph   = 1'b0;
    we        = 1'b0;
    waddr     = nd_q[AW-1:0];
    wdata     = par_q;
    raddr     = nd_q[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d = req_type_i;
          ql_d  = lo_c;
          qr_d  = hi_c;
          val_d = value_i;
          if (req_type_i == ramt_pkg::REQ_CLEAR) begin
            cnt_d   = '0;
            state_d = S_CLR;
          end else if (lo_c > hi_c) begin
            if (req_type_i == ramt_pkg::REQ_QUERY) begin
              acc_mn_d  = ramt_pkg::VMAX;
              acc_mx_d  = ramt_pkg::VMIN;
              acc_pos_d = '0;
              res_d     = 1'b1;
            end
          end else begin
            acc_mn_d  = ramt_pkg::VMAX;
            acc_mx_d  = ramt_pkg::VMIN;
            acc_pos_d = active_q + PW'(1);
            nd_d      = NW'(1);
            l_d       = PW'(1);
            r_d       = active_q;
            sp_d      = '0;
            state_d   = S_ENTER;
          end
        end
      end
      S_CLR: begin
        we       = 1'b1;
        waddr    = cnt_q;
        wdata    = '0;
        wdata.fresh = 1'b1;
        cnt_d    = cnt_q + AW'(1);
        if (cnt_q == AW'(NODES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_ENTER: begin
        state_d = nd_ok ? S_NODE : S_RET;
      end
      S_NODE: begin
        if (covered) begin
          if (req_q == ramt_pkg::REQ_QUERY) begin
            if (acc_mn_q > rd_n.mn || (acc_mn_q == rd_n.mn && acc_pos_q > rd_n.pos)) begin
              acc_mn_d  = rd_n.mn;
              acc_pos_d = rd_n.pos;
            end
            if (rd_n.mx > acc_mx_q) begin
              acc_mx_d = rd_n.mx;
            end
          end else begin
            we = 1'b1;
            if (req_q == ramt_pkg::REQ_SET) begin
              wdata = ramt_pkg::apply_set(rd_n, l_q, val_q);
            end else begin
              wdata = ramt_pkg::apply_add(rd_n, val_q);
            end
          end
          state_d = S_RET;
        end else begin
          par_d = rd_n;
          if (rd_n.setp || rd_n.add != '0) begin
            raddr   = lc[AW-1:0];
            state_d = S_PL;
          end else begin
            state_d = S_DESC;
          end
        end
      end
      S_PL: begin
        we      = lc_ok;
        waddr   = lc[AW-1:0];
        wdata   = ramt_pkg::push_child(rd_n, par_q, l_q);
        raddr   = rc[AW-1:0];
        state_d = S_PR;
      end
      S_PR: begin
        we      = rc_ok;
        waddr   = rc[AW-1:0];
        wdata   = ramt_pkg::push_child(rd_n, par_q, mid1);
        state_d = S_PW;
      end
      S_PW: begin
        we          = 1'b1;
        wdata       = par_q;
        wdata.fresh = 1'b0;
        wdata.setp  = 1'b0;
        wdata.add   = '0;
        state_d     = S_DESC;
      end
      S_DESC: begin
        if (ql_q <= mid) begin
          push    = 1'b1;
          push_ph = 1'b0;
          nd_d    = lc;
          r_d     = mid;
          state_d = S_ENTER;
        end else begin
          state_d = S_AFTERL;
        end
      end
      S_AFTERL: begin
        if (qr_q > mid) begin
          push    = 1'b1;
          push_ph = 1'b1;
          nd_d    = rc;
          l_d     = mid1;
          state_d = S_ENTER;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (req_q == ramt_pkg::REQ_QUERY || !rc_ok) begin
          state_d = S_RET;
        end else begin
          state_d = S_U0;
        end
      end
      S_U0: begin
        par_d   = rd_n;
        raddr   = lc[AW-1:0];
        state_d = S_UL;
      end
      S_UL: begin
        lch_d   = rd_n;
        raddr   = rc[AW-1:0];
        state_d = S_UR;
      end
      S_UR: begin
        we      = 1'b1;
        wdata   = ramt_pkg::pull_up(par_q, lch_q, rd_n);
        state_d = S_RET;
      end
      S_RET: begin
        if (sp_q == '0) begin
          res_d   = (req_q == ramt_pkg::REQ_QUERY);
          state_d = S_IDLE;
        end else begin
          nd_d    = stk_nd[top];
          l_d     = stk_l[top];
          r_d     = stk_r[top];
          sp_d    = sp_q - SPW'(1);
          state_d = stk_ph[top] ? S_FIN : S_AFTERL;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (push) begin
      sp_d = sp_q + SPW'(1);
    end

    if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_data_i == '0) begin
        active_d = PW'(1);
      end else if (32'(cfg_data_i) > LEAVES) begin
        active_d = PW'(LEAVES);
      end else begin
        active_d = cfg_data_i;
      end
      cnt_d   = '0;
      sp_d    = '0;
      state_d = S_CLR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      cnt_q    <= '0;
      active_q <= PW'(ACT_RST);
      sp_q     <= '0;
      res_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      active_q <= active_d;
      sp_q     <= sp_d;
      res_q    <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    ql_q      <= ql_d;
    qr_q      <= qr_d;
    val_q     <= val_d;
    nd_q      <= nd_d;
    l_q       <= l_d;
    r_q       <= r_d;
    par_q     <= par_d;
    lch_q     <= lch_d;
    acc_mn_q  <= acc_mn_d;
    acc_mx_q  <= acc_mx_d;
    acc_pos_q <= acc_pos_d;
    if (push) begin
      stk_nd[sp_q[SIW-1:0]] <= nd_q;
      stk_l[sp_q[SIW-1:0]]  <= l_q;
      stk_r[sp_q[SIW-1:0]]  <= r_q;
      stk_ph[sp_q[SIW-1:0]] <= push_ph;
    end
  end

endmodule
`default_nettype wire

@@ tb/sv/range_add_set_min_max_tree_tb.sv @@
// Self-checking testbench for the range add/set min-max tree: shadow tree predicts query results.
`timescale 1ns / 1ps
module range_add_set_min_max_tree_tb;

  localparam int           TREE_NODES = 2048;
  localparam int           STACK_DEPTH = 64;
  localparam longint       VAL_HI = 64'sd140737488355327;
  localparam longint       VAL_LO = -64'sd140737488355328;
  localparam logic [47:0]  W_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0]  W_MIN = 48'h8000_0000_0000;

  typedef struct {
    longint mn;
    int     pos;
    longint mx;
  } range_stats_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           start;
  logic                           busy;
  logic [1:0]                     req_type;
  logic [ramt_pkg::PW-1:0]        range_low;
  logic [ramt_pkg::PW-1:0]        range_high;
  logic signed [ramt_pkg::VW-1:0] value;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [ramt_pkg::PW-1:0]        cfg_data;
  logic                           result_valid;
  logic signed [ramt_pkg::VW-1:0] min_value;
  logic [ramt_pkg::PW-1:0]        min_position;
  logic signed [ramt_pkg::VW-1:0] max_value;

  longint tree_mn[TREE_NODES];
  longint tree_mx[TREE_NODES];
  int     tree_pos[TREE_NODES];
  bit     tree_setp[TREE_NODES];
  longint tree_setv[TREE_NODES];
  longint tree_add[TREE_NODES];
  int     size_shadow;

  range_stats_t pending_stats[$];
  int           fail_count;
  bit           idle_enable;

  range_add_set_min_max_tree dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type),
    .range_low_i    (range_low),
    .range_high_i   (range_high),
    .value_i        (value),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .result_valid_o (result_valid),
    .min_value_o    (min_value),
    .min_position_o (min_position),
    .max_value_o    (max_value)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint clip_sum(longint a, longint b);
    longint s;
    s = a + b;
    if (s > VAL_HI) return VAL_HI;
    if (s < VAL_LO) return VAL_LO;
    return s;
  endfunction

  function automatic void mark_set(int nd, int l, longint v);
    if (nd >= TREE_NODES) return;
    tree_setp[nd] = 1'b1;
    tree_setv[nd] = v;
    tree_add[nd]  = 0;
    tree_mn[nd]   = v;
    tree_mx[nd]   = v;
    tree_pos[nd]  = l;
  endfunction

  function automatic void mark_add(int nd, longint v);
    if (nd >= TREE_NODES) return;
    tree_add[nd] = clip_sum(tree_add[nd], v);
    tree_mn[nd]  = clip_sum(tree_mn[nd], v);
    tree_mx[nd]  = clip_sum(tree_mx[nd], v);
  endfunction

  function automatic void push_tags(int nd, int l, int m);
    if (tree_setp[nd]) begin
      mark_set(2 * nd, l, tree_setv[nd]);
      mark_set(2 * nd + 1, m + 1, tree_setv[nd]);
      tree_setp[nd] = 1'b0;
    end
    if (tree_add[nd] != 0) begin
      mark_add(2 * nd, tree_add[nd]);
      mark_add(2 * nd + 1, tree_add[nd]);
      tree_add[nd] = 0;
    end
  endfunction

  function automatic void merge_children(int nd);
    int a;
    int b;
    a = 2 * nd;
    b = a + 1;
    if (b >= TREE_NODES) return;
    if (tree_mn[a] <= tree_mn[b]) begin
      tree_mn[nd]  = tree_mn[a];
      tree_pos[nd] = tree_pos[a];
    end else begin
      tree_mn[nd]  = tree_mn[b];
      tree_pos[nd] = tree_pos[b];
    end
    tree_mx[nd] = (tree_mx[a] > tree_mx[b]) ? tree_mx[a] : tree_mx[b];
  endfunction

  function automatic void rebuild_tree();
    int fn[STACK_DEPTH];
    int fl[STACK_DEPTH];
    int fr[STACK_DEPTH];
    int sp;
    int nd;
    int l;
    int r;
    int m;
    for (int i = 0; i < TREE_NODES; i++) begin
      tree_mn[i] = 0; tree_mx[i] = 0; tree_pos[i] = 0;
      tree_setp[i] = 0; tree_setv[i] = 0; tree_add[i] = 0;
    end
    sp = 1; fn[0] = 1; fl[0] = 1; fr[0] = size_shadow;
    while (sp > 0) begin
      sp--;
      nd = fn[sp]; l = fl[sp]; r = fr[sp];
      if (nd < TREE_NODES) begin
        tree_mn[nd]  = VAL_HI;
        tree_pos[nd] = l;
        if (l < r) begin
          m = l + ((r - l) >> 1);
          fn[sp] = 2 * nd; fl[sp] = l; fr[sp] = m; sp++;
          fn[sp] = 2 * nd + 1; fl[sp] = m + 1; fr[sp] = r; sp++;
        end
      end
    end
  endfunction

  function automatic range_stats_t walk_range(logic [1:0] req, int lo, int hi, longint v);
    int fn[STACK_DEPTH];
    int fl[STACK_DEPTH];
    int fr[STACK_DEPTH];
    bit fph[STACK_DEPTH];
    int sp;
    int nd;
    int l;
    int r;
    int m;
    range_stats_t acc;
    acc.mn = VAL_HI; acc.mx = VAL_LO; acc.pos = size_shadow + 1;
    sp = 1; fn[0] = 1; fl[0] = 1; fr[0] = size_shadow; fph[0] = 0;
    while (sp > 0) begin
      nd = fn[sp-1]; l = fl[sp-1]; r = fr[sp-1];
      if (nd >= TREE_NODES) begin
        sp--;
      end else if (fph[sp-1]) begin
        if (req != ramt_pkg::REQ_QUERY) merge_children(nd);
        sp--;
      end else if (lo <= l && r <= hi) begin
        if (req == ramt_pkg::REQ_QUERY) begin
          if (acc.mn > tree_mn[nd] || (acc.mn == tree_mn[nd] && acc.pos > tree_pos[nd])) begin
            acc.mn  = tree_mn[nd];
            acc.pos = tree_pos[nd];
          end
          if (tree_mx[nd] > acc.mx) acc.mx = tree_mx[nd];
        end else if (req == ramt_pkg::REQ_SET) begin
          mark_set(nd, l, v);
        end else begin
          mark_add(nd, v);
        end
        sp--;
      end else begin
        m = l + ((r - l) >> 1);
        push_tags(nd, l, m);
        fph[sp-1] = 1'b1;
        if (hi > m) begin
          fn[sp] = 2 * nd + 1; fl[sp] = m + 1; fr[sp] = r; fph[sp] = 0; sp++;
        end
        if (lo <= m) begin
          fn[sp] = 2 * nd; fl[sp] = l; fr[sp] = m; fph[sp] = 0; sp++;
        end
      end
    end
    return acc;
  endfunction

  function automatic void predict_request(logic [1:0] req, logic [ramt_pkg::PW-1:0] lo_in,
                                          logic [ramt_pkg::PW-1:0] hi_in,
                                          logic signed [ramt_pkg::VW-1:0] v_in);
    int lo;
    int hi;
    range_stats_t acc;
    lo = lo_in;
    hi = hi_in;
    if (lo < 1) lo = 1;
    if (hi > size_shadow) hi = size_shadow;
    case (req)
      ramt_pkg::REQ_CLEAR: rebuild_tree();
      ramt_pkg::REQ_ADD, ramt_pkg::REQ_SET:
        if (lo <= hi) acc = walk_range(req, lo, hi, longint'(v_in));
      default: begin
        if (lo > hi) begin
          acc.mn = VAL_HI; acc.mx = VAL_LO; acc.pos = 0;
        end else begin
          acc = walk_range(req, lo, hi, 0);
        end
        pending_stats.push_back(acc);
      end
    endcase
  endfunction

  always @(posedge clk_i) begin
    range_stats_t want;
    if (rst_ni && result_valid) begin
      if (pending_stats.size() == 0) begin
        $error("result with no query outstanding");
        fail_count++;
      end else begin
        want = pending_stats.pop_front();
        if (min_value !== want.mn[47:0]) begin
          $error("min_value expected %0d actual %0d", want.mn, min_value);
          fail_count++;
        end
        if (min_position !== want.pos[10:0]) begin
          $error("min_position expected %0d actual %0d", want.pos, min_position);
          fail_count++;
        end
        if (max_value !== want.mx[47:0]) begin
          $error("max_value expected %0d actual %0d", want.mx, max_value);
          fail_count++;
        end
      end
    end
  end

  function automatic logic [47:0] rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0];
  endfunction

  task automatic send_request(logic [1:0] req, logic [ramt_pkg::PW-1:0] lo,
                              logic [ramt_pkg::PW-1:0] hi, logic [47:0] v);
    if (idle_enable && $urandom_range(99) < 38) begin
      start = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    req_type   = req;
    range_low  = lo;
    range_high = hi;
    value      = v;
    start      = 1'b1;
    do @(posedge clk_i); while (busy);
    predict_request(req, lo, hi, v);
    @(negedge clk_i);
    start = 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_size(logic [ramt_pkg::PW-1:0] d);
    int s;
    wait_idle();
    cfg_valid = 1'b1;
    cfg_data  = d;
    do @(posedge clk_i); while (!cfg_ready);
    s = d;
    if (s < 1) s = 1;
    if (s > 1024) s = 1024;
    size_shadow = s;
    rebuild_tree();
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  task automatic random_request();
    int pick;
    int lo;
    int hi;
    int t;
    logic [1:0] req;
    logic [47:0] v;
    pick = $urandom_range(99);
    if (pick < 2) req = ramt_pkg::REQ_CLEAR;
    else if (pick < 37) req = ramt_pkg::REQ_ADD;
    else if (pick < 67) req = ramt_pkg::REQ_SET;
    else req = ramt_pkg::REQ_QUERY;
    if ($urandom_range(99) < 85) begin
      lo = $urandom_range(size_shadow, 1);
      hi = $urandom_range(size_shadow, 1);
      if (lo > hi) begin t = lo; lo = hi; hi = t; end
    end else begin
      lo = $urandom_range(2047);
      hi = $urandom_range(2047);
    end
    pick = $urandom_range(99);
    if (pick < 70) v = 48'(longint'($urandom_range(2097152)) - 64'sd1048576);
    else if (pick < 85) v = rand48();
    else case ($urandom_range(3))
      0: v = W_MAX;
      1: v = W_MIN;
      2: v = '0;
      default: v = '1;
    endcase
    send_request(req, lo[10:0], hi[10:0], v);
  endtask

  task automatic test_reset_contents();
    send_request(ramt_pkg::REQ_QUERY, 11'd1, 11'd1024, '0);
    send_request(ramt_pkg::REQ_QUERY, 11'd0, 11'd2047, '0);
    send_request(ramt_pkg::REQ_QUERY, 11'd512, 11'd512, '0);
  endtask

  task automatic test_empty_ranges();
    send_request(ramt_pkg::REQ_QUERY, 11'd10, 11'd9, '0);
    send_request(ramt_pkg::REQ_ADD, 11'd700, 11'd3, 48'd5);
    send_request(ramt_pkg::REQ_SET, 11'd1500, 11'd2047, 48'd7);
    send_request(ramt_pkg::REQ_QUERY, 11'd2047, 11'd2047, '0);
  endtask

  task automatic test_set_and_add();
    send_request(ramt_pkg::REQ_SET, 11'd0, 11'd2047, 48'd65536);
    send_request(ramt_pkg::REQ_SET, 11'd300, 11'd400, W_MIN);
    send_request(ramt_pkg::REQ_ADD, 11'd1, 11'd1024, '1);
    send_request(ramt_pkg::REQ_QUERY, 11'd1, 11'd1024, '0);
    send_request(ramt_pkg::REQ_SET, 11'd5, 11'd900, 48'd3);
    send_request(ramt_pkg::REQ_QUERY, 11'd4, 11'd901, '0);
  endtask

  task automatic test_saturation();
    send_request(ramt_pkg::REQ_ADD, 11'd1, 11'd512, W_MAX);
    send_request(ramt_pkg::REQ_ADD, 11'd1, 11'd1024, W_MAX);
    send_request(ramt_pkg::REQ_QUERY, 11'd1, 11'd1024, '0);
    send_request(ramt_pkg::REQ_ADD, 11'd200, 11'd800, W_MIN);
    send_request(ramt_pkg::REQ_ADD, 11'd100, 11'd900, W_MIN);
    send_request(ramt_pkg::REQ_QUERY, 11'd1, 11'd1024, '0);
    send_request(ramt_pkg::REQ_QUERY, 11'd150, 11'd150, '0);
  endtask

  task automatic test_clear();
    send_request(ramt_pkg::REQ_CLEAR, 11'h7FF, 11'h7FF, '1);
    send_request(ramt_pkg::REQ_QUERY, 11'd1, 11'd1024, '0);
  endtask

  task automatic test_size_extremes();
    write_size(11'd0);
    send_request(ramt_pkg::REQ_SET, 11'd1, 11'd1, W_MIN);
    send_request(ramt_pkg::REQ_QUERY, 11'd0, 11'd2047, '0);
    write_size(11'h7FF);
    send_request(ramt_pkg::REQ_QUERY, 11'd1, 11'd1024, '0);
  endtask

  task automatic test_random(int items);
    logic [ramt_pkg::PW-1:0] sizes[5];
    sizes = '{11'd1024, 11'd1, 11'd37, 11'd600, 11'd1024};
    foreach (sizes[p]) begin
      write_size(sizes[p]);
      for (int i = 0; i < items / 5; i++) begin
        idle_enable = !(p == 2 && i >= 20 && i < 70);
        random_request();
      end
    end
    idle_enable = 1'b1;
  endtask

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    req_type    = ramt_pkg::REQ_CLEAR;
    range_low   = '0;
    range_high  = '0;
    value       = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    fail_count  = 0;
    idle_enable = 1'b1;
    size_shadow = 1024;
    rebuild_tree();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_contents();
    test_empty_ranges();
    test_set_and_add();
    test_saturation();
    test_clear();
    test_size_extremes();
    test_random(500);
    wait_idle();
    if (fail_count == 0) begin
      $display("range_add_set_min_max_tree regression: pass");
    end else begin
      $display("range_add_set_min_max_tree regression: fail");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("range_add_set_min_max_tree regression: fail");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/ramt_pkg.sv
hw/rtl/ramt_ram.sv
hw/rtl/range_add_set_min_max_tree.sv
tb/sv/range_add_set_min_max_tree_tb.sv
